// File: hw/rtl/bit_pkg.sv
// ----------------------------------------------------------------------------
// bit_pkg
// Shared types and constants for the binary image thinning block.
// ----------------------------------------------------------------------------
`default_nettype none
package bit_pkg;
  localparam int unsigned DimW = 7;
  localparam int unsigned RowW = 64;
  localparam int unsigned IdxW = 6;

  // register indexes on the configuration channel
  localparam logic CfgWidth  = 1'b0;
  localparam logic CfgHeight = 1'b1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SWEEP,
    ST_NEXT,
    ST_EMIT
  } state_e;

  // control handed to every cell of the chain
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;
endpackage
`default_nettype wire

// File: hw/rtl/bit_row_cell.sv
// ----------------------------------------------------------------------------
// bit_row_cell
// One row of the image. Rows rotate upward through the chain; the row at the
// chain head is tested against its two neighbors outside the cell.
// ----------------------------------------------------------------------------
`default_nettype none
module bit_row_cell (
  input  wire logic               clk_i,
  input  wire bit_pkg::cell_ctl_t ctl_i,
  input  wire logic [63:0]        load_row_i,
  input  wire logic [63:0]        next_row_i,
  output logic [63:0]             row_o
);
  logic [63:0] row_q;
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      row_q <= load_row_i;
    end else if (ctl_i.shift) begin
      row_q <= next_row_i;
    end
  end
  assign row_o = row_q;
endmodule
`default_nettype wire

// File: hw/rtl/bit_thin_row.sv
// ----------------------------------------------------------------------------
// bit_thin_row
// Zhang-Suen test of a whole row against the rows above and below it.
// ----------------------------------------------------------------------------
`default_nettype none
module bit_thin_row (
  input  wire logic [63:0] up_i,
  input  wire logic [63:0] mid_i,
  input  wire logic [63:0] dn_i,
  input  wire logic [63:0] colmask_i,
  input  wire logic        step_i,
  output logic [63:0]      mark_o
);
  always_comb begin
    logic [7:0] p;
    logic [3:0] cnt;
    logic [3:0] tr;
    mark_o = '0;
    for (int c = 1; c < 63; c++) begin
      p[0] = up_i[c];   p[1] = up_i[c+1]; p[2] = mid_i[c+1]; p[3] = dn_i[c+1];
      p[4] = dn_i[c];   p[5] = dn_i[c-1]; p[6] = mid_i[c-1]; p[7] = up_i[c-1];
      cnt = '0;
      tr  = '0;
      for (int i = 0; i < 8; i++) begin
        cnt = cnt + 4'(p[i]);
        tr  = tr + 4'(!p[i] && p[(i + 1) % 8]);
      end
      mark_o[c] = mid_i[c] && colmask_i[c] && (tr == 4'd1) && (cnt >= 4'd2)
                  && (cnt <= 4'd6)
                  && (step_i ? (!(p[0] & p[2] & p[6]) && !(p[0] & p[4] & p[6]))
                             : (!(p[0] & p[2] & p[4]) && !(p[2] & p[4] & p[6])));
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/binary_image_thinning.sv
// w*h pixel beats load one per cycle while in_valid is high and no cfg beat is
// offered; the last one sets pend_q for a setup step, then each subiteration
// rotates the h rows through the chain of row cells (ST_SWEEP) and ST_NEXT closes
// it; passes repeat until one removes nothing; then h row beats are emitted, one
// per cycle while out_ready is high. A new image is taken only after the last row.
// reset clears control and counters; image rows hold no reset value.
// ----------------------------------------------------------------------------
// binary_image_thinning
// Zhang-Suen thinning over a rotating chain of row cells.
// ----------------------------------------------------------------------------
`default_nettype none
module binary_image_thinning #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  pixel_value_i,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [6:0]  cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      row_bits_o,
  output logic [5:0]       row_index_o,
  output logic             last_row_o
);
  localparam int unsigned HW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT + 1) : 1;
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);

  bit_pkg::state_e st_q, st_d;
  logic [6:0] wreg_q, hreg_q;
  logic [CW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [CW-1:0] col_q;
  logic [HW-1:0] row_q, cnt_q;
  logic step_q, chg_q, any_q;
  logic [63:0] acc_q;
  logic [63:0] rows [MAX_HEIGHT];
  logic [63:0] colmask;
  logic chain_shift;
  logic row_done, acc_fg;
  logic [63:0] acc_new;
  logic pend_q;

  always_comb begin
    if (wreg_q == 7'd0) w_eff = CW'(1);
    else if (32'(wreg_q) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(wreg_q);
    if (hreg_q == 7'd0) h_eff = HW'(1);
    else if (32'(hreg_q) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(hreg_q);
  end

  always_comb begin
    for (int c = 0; c < 64; c++) colmask[c] = (c + 1 < int'(w_eff));
  end

  // border rows (first and last in use) are never marked
  logic head_interior;
  assign head_interior = (cnt_q != '0) && (cnt_q != h_eff - HW'(1));

  // the up neighbor of the head must be the original row: keep it in a register
  logic [63:0] prev_q;
  logic [63:0] first_q;

  assign chain_shift = (st_q == bit_pkg::ST_SWEEP) ||
                       (st_q == bit_pkg::ST_EMIT && out_valid && out_ready);

  logic [63:0] up_row, dn_row, mark_s;
  assign up_row = (cnt_q == '0) ? '0 : prev_q;
  assign dn_row = (cnt_q == h_eff - HW'(1)) ? first_q : rows[1 % MAX_HEIGHT];
  bit_thin_row u_thin2 (
    .up_i(up_row), .mid_i(rows[0]), .dn_i(dn_row),
    .colmask_i(colmask), .step_i(step_q), .mark_o(mark_s)
  );
  logic [63:0] new_head;
  assign new_head = head_interior ? (rows[0] & ~mark_s) : rows[0];

  for (genvar g = 0; g < MAX_HEIGHT; g++) begin : g_cell
    logic [63:0] nxt, ld;
    bit_pkg::cell_ctl_t c_ctl;
    if (g == MAX_HEIGHT - 1) begin : g_tail
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = rows[g + 1];
    end
    always_comb begin
      ld = nxt;
      if (st_q == bit_pkg::ST_SWEEP && HW'(g) == h_eff - HW'(1)) ld = new_head;
      if (st_q == bit_pkg::ST_EMIT && HW'(g) == h_eff - HW'(1)) ld = rows[0];
      if (st_q == bit_pkg::ST_LOAD && HW'(g) == h_eff - HW'(1)) ld = acc_new;
    end
    always_comb begin
      c_ctl.load  = (HW'(g) == h_eff - HW'(1)) && (chain_shift ||
                    (st_q == bit_pkg::ST_LOAD && row_done));
      c_ctl.shift = (HW'(g) < h_eff - HW'(1)) && (chain_shift ||
                    (st_q == bit_pkg::ST_LOAD && row_done));
    end
    bit_row_cell u_cell (
      .clk_i(clk_i), .ctl_i(c_ctl), .load_row_i(ld), .next_row_i(nxt),
      .row_o(rows[g])
    );
  end

  assign acc_fg = pixel_value_i[7];
  always_comb begin
    acc_new = (col_q == '0) ? '0 : acc_q;
    acc_new[6'(col_q)] = acc_fg;
  end
  assign in_ready  = (st_q == bit_pkg::ST_LOAD) && !pend_q && !cfg_valid;
  assign cfg_ready = (st_q == bit_pkg::ST_LOAD) && !pend_q;
  assign row_done  = in_valid && in_ready && (col_q == w_eff - CW'(1));

  always_ff @(posedge clk_i) begin
    if (in_valid && in_ready) acc_q <= acc_new;
    if (st_q == bit_pkg::ST_SWEEP) begin
      prev_q <= rows[0];
      if (cnt_q == '0) first_q <= rows[0];
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      bit_pkg::ST_LOAD:  if (pend_q) st_d = bit_pkg::ST_SWEEP;
      bit_pkg::ST_SWEEP: if (cnt_q == h_eff - HW'(1)) st_d = bit_pkg::ST_NEXT;
      bit_pkg::ST_NEXT:  if (step_q && !(chg_q || any_q)) st_d = bit_pkg::ST_EMIT;
                         else st_d = bit_pkg::ST_SWEEP;
      bit_pkg::ST_EMIT:  if (out_ready && cnt_q == h_eff - HW'(1))
                           st_d = bit_pkg::ST_LOAD;
      default: st_d = bit_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= bit_pkg::ST_LOAD; wreg_q <= 7'd64; hreg_q <= 7'd64;
      col_q <= '0; row_q <= '0; cnt_q <= '0; step_q <= 1'b0;
      chg_q <= 1'b0; any_q <= 1'b0; pend_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == bit_pkg::CfgWidth) wreg_q <= cfg_data; else hreg_q <= cfg_data;
        col_q <= '0; row_q <= '0;
      end else if (in_valid && in_ready) begin
        if (col_q == w_eff - CW'(1)) begin
          col_q <= '0;
          if (row_q == h_eff - HW'(1)) begin row_q <= '0; pend_q <= 1'b1; end
          else row_q <= row_q + HW'(1);
        end else col_q <= col_q + CW'(1);
      end
      if (st_q == bit_pkg::ST_LOAD && pend_q) begin
        pend_q <= 1'b0; cnt_q <= '0; step_q <= 1'b0; chg_q <= 1'b0; any_q <= 1'b0;
      end
      if (st_q == bit_pkg::ST_SWEEP) begin
        if (head_interior && |(mark_s)) any_q <= 1'b1;
        cnt_q <= (cnt_q == h_eff - HW'(1)) ? '0 : cnt_q + HW'(1);
      end
      if (st_q == bit_pkg::ST_NEXT) begin
        if (step_q) begin chg_q <= 1'b0; end else chg_q <= any_q;
        any_q <= 1'b0; step_q <= ~step_q;
        if (step_q && !(chg_q || any_q)) cnt_q <= '0;
      end
      if (st_q == bit_pkg::ST_EMIT && out_ready)
        cnt_q <= (cnt_q == h_eff - HW'(1)) ? '0 : cnt_q + HW'(1);
    end
  end

  logic [63:0] wmask;
  always_comb for (int c = 0; c < 64; c++) wmask[c] = (c < int'(w_eff));
  assign out_valid   = (st_q == bit_pkg::ST_EMIT);
  assign row_bits_o  = rows[0] & wmask;
  assign row_index_o = 6'(cnt_q);
  assign last_row_o  = (cnt_q == h_eff - HW'(1));

  a_no_in_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != bit_pkg::ST_LOAD) |-> !in_ready) else $error("input taken while busy");
  a_out_only_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (st_q == bit_pkg::ST_EMIT)) else $error("output outside emit");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (cnt_q < h_eff)) else $error("row index out of range");
  a_pend_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !(in_ready || cfg_ready)) else $error("beat taken before thinning");
endmodule
`default_nettype wire
